>>> rtl/core/iccr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iccr_pkg
// Shared constants, register codes and the firmware-name table of the ISA
// card control register block.
// ----------------------------------------------------------------------------
package iccr_pkg;

    // default parameter values
    localparam int NAME_DEPTH_DEF   = 64;
    localparam int DEFAULT_BASE_DEF = 544;
    localparam int CONTROL_ADDR_DEF = 464;

    // access kinds carried on s_tuser
    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    localparam logic [7:0] UNLOCK_KEY       = 8'hCC;
    localparam logic [7:0] MAGIC_BYTE       = 8'hDD;
    localparam logic [7:0] PROTOCOL_VERSION = 8'h01;
    localparam logic [7:0] UNKNOWN_READ     = 8'hFF;

    // register select codes
    localparam logic [7:0] REG_MAGIC   = 8'h00;
    localparam logic [7:0] REG_VERSION = 8'h01;
    localparam logic [7:0] REG_NAME    = 8'h02;
    localparam logic [7:0] REG_MODE    = 8'h03;
    localparam logic [7:0] REG_BASE    = 8'h04;

    localparam int FW_NAME_LEN = 19;
    localparam logic [8*FW_NAME_LEN-1:0] FW_NAME = "ISA sound card v1.0";

    typedef logic [7:0] byte_t;

    // name table entry: the string, zero filled, last entry always zero
    function automatic byte_t name_rom_byte(input logic [7:0] idx, input int depth);
        byte_t b;
        b = 8'h00;
        if (int'(idx) < FW_NAME_LEN && int'(idx) < depth - 1) begin
            b = FW_NAME[8*(FW_NAME_LEN-1-int'(idx)) +: 8];
        end
        return b;
    endfunction

endpackage

>>> rtl/core/isa_card_control_registers_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isa_card_control_registers_unit
// Decodes control, data-low and data-high I/O ports of the card: unlock key,
// register select, magic/version/name/mode reads and the base-port register.
// ----------------------------------------------------------------------------
// Each request (one I/O access) is decoded and applied to the register state
// in the cycle it is accepted; its result appears on the m_ side in the next cycle
// from the output register. A new request is accepted every cycle while
// that register is empty or being drained, so the sustained rate is one
// request per clock, set by the single register stage that holds both the
// control state and the result. cfg_data sets the card mode and is always
// ready.
module isa_card_control_registers_unit
    import iccr_pkg::*;
#(
    parameter int NAME_DEPTH   = NAME_DEPTH_DEF,
    parameter int DEFAULT_BASE = DEFAULT_BASE_DEF,
    parameter int CONTROL_ADDR = CONTROL_ADDR_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] port, [17:10] write_data, [23:18] zero
    input  logic        s_tuser,   // [0] mode (0 read, 1 write)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] read_data, [8] claimed, [9] wait_state, [15:10] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // card_mode
);

    localparam int IW = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
    localparam logic [IW-1:0] NAME_LAST = IW'(NAME_DEPTH - 1);
    localparam logic [9:0] CTL_PORT = 10'(CONTROL_ADDR);
    localparam logic [9:0] DLO_PORT = 10'(CONTROL_ADDR + 1);
    localparam logic [9:0] DHI_PORT = 10'(CONTROL_ADDR + 2);

    logic          unlocked_reg, unlocked_next;
    logic [7:0]    sel_reg, sel_next;
    logic [7:0]    low_latch_reg, low_latch_next;
    logic [15:0]   base_reg, base_next;
    logic [IW-1:0] name_idx_reg, name_idx_next;
    logic [7:0]    card_mode_reg;
    logic          m_tvalid_reg;
    logic [15:0]   m_tdata_reg;

    logic       s_accept;
    logic       is_wr;
    logic [9:0] in_port;
    logic [7:0] in_data;
    logic [7:0] name_byte;
    logic [7:0] rd;
    logic       clm;
    logic       wt;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign is_wr     = (s_tuser == ACC_WRITE);
    assign in_port   = s_tdata[9:0];
    assign in_data   = s_tdata[17:10];
    assign name_byte = name_rom_byte(8'(name_idx_reg), NAME_DEPTH);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        unlocked_next  = unlocked_reg;
        sel_next       = sel_reg;
        low_latch_next = low_latch_reg;
        base_next      = base_reg;
        name_idx_next  = name_idx_reg;
        rd             = 8'h00;
        clm            = 1'b1;
        wt             = 1'b1;
        if (in_port == CTL_PORT) begin
            if (is_wr) begin
                if (in_data == UNLOCK_KEY) begin
                    unlocked_next = 1'b1;
                end else if (unlocked_reg) begin
                    sel_next = in_data;
                    if (in_data == REG_NAME) begin
                        name_idx_next = '0;
                    end else if (in_data == REG_BASE) begin
                        low_latch_next = 8'h00;
                    end else if (in_data > REG_BASE) begin
                        unlocked_next = 1'b0;
                    end
                end
            end else begin
                rd = sel_reg;
            end
        end else if (in_port == DLO_PORT) begin
            if (is_wr) begin
                wt = 1'b0;
                if (unlocked_reg && sel_reg == REG_BASE) begin
                    low_latch_next = in_data;
                end
            end else if (sel_reg == REG_BASE) begin
                rd = base_reg[7:0];
            end
        end else if (in_port == DHI_PORT) begin
            if (is_wr) begin
                if (unlocked_reg && sel_reg == REG_BASE) begin
                    base_next = {in_data, low_latch_reg};
                end
            end else begin
                case (sel_reg)
                    REG_MAGIC:   rd = MAGIC_BYTE;
                    REG_VERSION: rd = PROTOCOL_VERSION;
                    REG_NAME: begin
                        rd = name_byte;
                        // wrap on the terminator or at the end of the table
                        if (name_byte == 8'h00 || name_idx_reg == NAME_LAST) begin
                            name_idx_next = '0;
                        end else begin
                            name_idx_next = IW'(name_idx_reg + 1'b1);
                        end
                    end
                    REG_MODE:    rd = card_mode_reg;
                    REG_BASE:    rd = base_reg[15:8];
                    default:     rd = UNKNOWN_READ;
                endcase
            end
        end else begin
            clm = 1'b0;
            wt  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unlocked_reg  <= 1'b0;
            sel_reg       <= 8'h00;
            low_latch_reg <= 8'h00;
            base_reg      <= 16'(DEFAULT_BASE);
            name_idx_reg  <= '0;
            card_mode_reg <= 8'h00;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                card_mode_reg <= cfg_data;
            end
            if (s_accept) begin
                unlocked_reg  <= unlocked_next;
                sel_reg       <= sel_next;
                low_latch_reg <= low_latch_next;
                base_reg      <= base_next;
                name_idx_reg  <= name_idx_next;
                m_tvalid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {6'b000000, wt, clm, rd};
        end
    end

`ifndef SYNTHESIS
    // an unclaimed port never drives data or asks for a wait
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[8]) |-> (m_tdata[7:0] == 8'h00 && !m_tdata[9]))
        else $error("unclaimed access produced data or wait");

    // selecting an unknown register while unlocked locks the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_wr && in_port == CTL_PORT && unlocked_reg &&
         in_data != UNLOCK_KEY && in_data > REG_BASE) |=> !unlocked_reg)
        else $error("unknown register select did not lock");

    // every accepted request leaves a result in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted request produced no result");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ISA I/O accesses into isa_card_control_registers_unit and checks
// every reply against a cycle-free model of the control register decoder:
// a directed table first, then random unlock/select/data sequences mixed
// with stray accesses, over several card mode settings and random stalls.
// ----------------------------------------------------------------------------
module testbench;
    import iccr_pkg::*;

    localparam logic [9:0] CTL_PORT = 10'(CONTROL_ADDR_DEF);
    localparam logic [9:0] DLO_PORT = 10'(CONTROL_ADDR_DEF + 1);
    localparam logic [9:0] DHI_PORT = 10'(CONTROL_ADDR_DEF + 2);

    typedef struct packed {
        logic [7:0] rd;
        logic       claimed;
        logic       slow;
    } io_reply_t;

    typedef struct packed {
        logic       wr;
        logic [9:0] port;
        logic [7:0] wd;
        logic       fixed;
        io_reply_t  want;
    } io_access_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'h00;

    always #5 aclk = ~aclk;

    isa_card_control_registers_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // decoder model state
    string      fw_text = "ISA sound card v1.0";
    byte_t      name_tbl [NAME_DEPTH_DEF];
    logic [7:0] card_mode_m;
    logic       unlocked_m;
    logic [7:0] sel_m;
    logic [7:0] latch_m;
    logic [15:0] base_m;
    int         name_pos;

    io_reply_t  bus_replies_due [$];
    io_access_t directed_rows [$];
    int         reply_mismatches = 0;
    int         replies_seen     = 0;
    int         claimed_accesses = 0;
    int         tx_calm          = 0;

    // receiver side
    int         rx_hold        = 0;
    int         rx_calm        = 0;
    int         rx_roll;
    bit         long_hold_done = 1'b0;
    io_reply_t  want_r;
    io_reply_t  got_r;

    function automatic int stall_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_gap();
        if (tx_calm > 0) begin
            tx_calm--;
            return 0;
        end
        if ($urandom_range(0, 99) < 55) return 0;
        return stall_len();
    endfunction

    task automatic decode_io_access(input logic wr, input logic [9:0] port,
                                    input logic [7:0] wd, output io_reply_t res);
        res.rd      = 8'h00;
        res.claimed = 1'b1;
        res.slow    = 1'b1;
        if (port == CTL_PORT) begin
            if (wr == ACC_WRITE) begin
                if (wd == UNLOCK_KEY) begin
                    unlocked_m = 1'b1;
                end else if (unlocked_m) begin
                    sel_m = wd;
                    if (wd == REG_NAME) name_pos = 0;
                    else if (wd == REG_BASE) latch_m = 8'h00;
                    else if (wd > REG_BASE) unlocked_m = 1'b0;
                end
            end else begin
                res.rd = sel_m;
            end
        end else if (port == DLO_PORT) begin
            if (wr == ACC_WRITE) begin
                res.slow = 1'b0;
                if (unlocked_m && sel_m == REG_BASE) latch_m = wd;
            end else if (sel_m == REG_BASE) begin
                res.rd = base_m[7:0];
            end
        end else if (port == DHI_PORT) begin
            if (wr == ACC_WRITE) begin
                if (unlocked_m && sel_m == REG_BASE) base_m = {wd, latch_m};
            end else begin
                case (sel_m)
                    REG_MAGIC:   res.rd = MAGIC_BYTE;
                    REG_VERSION: res.rd = PROTOCOL_VERSION;
                    REG_NAME: begin
                        if (name_pos >= NAME_DEPTH_DEF) name_pos = 0;
                        res.rd = name_tbl[name_pos];
                        name_pos++;
                        // zero terminator or end of table restarts the name
                        if (res.rd == 8'h00 || name_pos >= NAME_DEPTH_DEF) name_pos = 0;
                    end
                    REG_MODE:    res.rd = card_mode_m;
                    REG_BASE:    res.rd = base_m[15:8];
                    default:     res.rd = UNKNOWN_READ;
                endcase
            end
        end else begin
            res.claimed = 1'b0;
            res.slow    = 1'b0;
        end
    endtask

    task automatic send_access(input logic wr, input logic [9:0] port, input logic [7:0] wd,
                               input logic use_fixed, input io_reply_t fixed_reply);
        io_reply_t res;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, wd, port};
        s_tuser  <= wr;
        do @(posedge aclk); while (!s_tready);
        decode_io_access(wr, port, wd, res);
        bus_replies_due.push_back(use_fixed ? fixed_reply : res);
        if (res.claimed) claimed_accesses++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic add_row(input logic wr, input logic [9:0] port, input logic [7:0] wd,
                           input logic fixed, input logic [7:0] rd, input logic cl,
                           input logic sl);
        io_access_t row;
        row.wr           = wr;
        row.port         = port;
        row.wd           = wd;
        row.fixed        = fixed;
        row.want.rd      = rd;
        row.want.claimed = cl;
        row.want.slow    = sl;
        directed_rows.push_back(row);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (bus_replies_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_random_phase(input int target);
        int start;
        int r;
        int k;
        int i;
        logic [7:0] pick;
        logic [7:0] wd;
        start = claimed_accesses;
        while (claimed_accesses - start < target) begin
            if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 60);
            r = $urandom_range(0, 99);
            if (r < 55) begin
                // unlock, select, then a burst of data and control port requests
                send_access(ACC_WRITE, CTL_PORT, UNLOCK_KEY, 1'b0, '0);
                if ($urandom_range(0, 7) != 0) pick = 8'($urandom_range(0, 4));
                else pick = 8'($urandom_range(5, 255));
                send_access(ACC_WRITE, CTL_PORT, pick, 1'b0, '0);
                k = (pick == REG_NAME) ? $urandom_range(1, 24) : $urandom_range(1, 10);
                for (i = 0; i < k; i++) begin
                    r  = $urandom_range(0, 99);
                    wd = 8'($urandom_range(0, 255));
                    if (r < 40) send_access(ACC_READ, DHI_PORT, wd, 1'b0, '0);
                    else if (r < 55) send_access(ACC_READ, DLO_PORT, wd, 1'b0, '0);
                    else if (r < 70) send_access(ACC_WRITE, DLO_PORT, wd, 1'b0, '0);
                    else if (r < 85) send_access(ACC_WRITE, DHI_PORT, wd, 1'b0, '0);
                    else if (r < 93) send_access(ACC_READ, CTL_PORT, wd, 1'b0, '0);
                    else send_access(ACC_WRITE, CTL_PORT, wd, 1'b0, '0);
                end
            end else if (r < 80) begin
                if ($urandom_range(0, 7) == 0) wd = UNLOCK_KEY;
                else wd = 8'($urandom_range(0, 255));
                send_access(1'($urandom_range(0, 1)), CTL_PORT + 10'($urandom_range(0, 2)),
                            wd, 1'b0, '0);
            end else begin
                send_access(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                            8'($urandom_range(0, 255)), 1'b0, '0);
            end
        end
    endtask

    // receiver: short random stalls, calm stretches and one long hold-off
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else if (!long_hold_done && replies_seen >= 400) begin
            m_tready <= 1'b0;
            rx_hold = 150;
            long_hold_done = 1'b1;
        end else if (rx_calm > 0) begin
            m_tready <= 1'b1;
            rx_calm--;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 3) begin
                m_tready <= 1'b1;
                rx_calm = $urandom_range(30, 120);
            end else if (rx_roll < 18) begin
                m_tready <= 1'b0;
                rx_hold = stall_len() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_r.rd      = m_tdata[7:0];
            got_r.claimed = m_tdata[8];
            got_r.slow    = m_tdata[9];
            if (bus_replies_due.size() == 0) begin
                reply_mismatches++;
                if (reply_mismatches <= 10)
                    $display("unexpected reply rd=%02h claimed=%0b wait=%0b",
                             got_r.rd, got_r.claimed, got_r.slow);
            end else begin
                want_r = bus_replies_due.pop_front();
                if (got_r.rd !== want_r.rd || got_r.claimed !== want_r.claimed ||
                    got_r.slow !== want_r.slow) begin
                    reply_mismatches++;
                    if (reply_mismatches <= 10)
                        $display({"reply %0d: expected rd=%02h claimed=%0b wait=%0b, ",
                                  "got rd=%02h claimed=%0b wait=%0b"},
                                 replies_seen, want_r.rd, want_r.claimed, want_r.slow,
                                 got_r.rd, got_r.claimed, got_r.slow);
                end
            end
            replies_seen++;
        end
    end

    initial begin : main_flow
        int i;
        int ph;
        logic [7:0] mode_val;

        for (i = 0; i < NAME_DEPTH_DEF; i++)
            name_tbl[i] = (i < fw_text.len() && i < NAME_DEPTH_DEF - 1) ? fw_text[i] : 8'h00;
        card_mode_m = 8'h00;
        unlocked_m  = 1'b0;
        sel_m       = 8'h00;
        latch_m     = 8'h00;
        base_m      = 16'(DEFAULT_BASE_DEF);
        name_pos    = 0;

        // directed table: fixed replies where they are plain, model elsewhere
        add_row(ACC_READ,  CTL_PORT, 8'h00, 1'b1, 8'h00, 1'b1, 1'b1);
        add_row(ACC_READ,  DHI_PORT, 8'h00, 1'b1, MAGIC_BYTE, 1'b1, 1'b1);
        add_row(ACC_READ,  DLO_PORT, 8'h00, 1'b1, 8'h00, 1'b1, 1'b1);
        // locked: select and data writes are dropped
        add_row(ACC_WRITE, CTL_PORT, REG_BASE, 1'b1, 8'h00, 1'b1, 1'b1);
        add_row(ACC_WRITE, DLO_PORT, 8'hAA, 1'b1, 8'h00, 1'b1, 1'b0);
        add_row(ACC_WRITE, CTL_PORT, UNLOCK_KEY, 1'b1, 8'h00, 1'b1, 1'b1);
        add_row(ACC_WRITE, CTL_PORT, REG_VERSION, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(ACC_READ,  DHI_PORT, 8'h00, 1'b1, PROTOCOL_VERSION, 1'b1, 1'b1);
        add_row(ACC_WRITE, CTL_PORT, REG_NAME, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(ACC_READ,  DHI_PORT, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(ACC_READ,  DHI_PORT, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(ACC_WRITE, CTL_PORT, REG_MODE, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(ACC_READ,  DHI_PORT, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(ACC_WRITE, CTL_PORT, REG_BASE, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(ACC_READ,  DLO_PORT, 8'h00, 1'b1, 8'h20, 1'b1, 1'b1);
        add_row(ACC_READ,  DHI_PORT, 8'h00, 1'b1, 8'h02, 1'b1, 1'b1);
        add_row(ACC_WRITE, DLO_PORT, 8'hFF, 1'b1, 8'h00, 1'b1, 1'b0);
        add_row(ACC_WRITE, DHI_PORT, 8'hFF, 1'b1, 8'h00, 1'b1, 1'b1);
        add_row(ACC_READ,  DLO_PORT, 8'h00, 1'b1, 8'hFF, 1'b1, 1'b1);
        add_row(ACC_READ,  DHI_PORT, 8'h00, 1'b1, 8'hFF, 1'b1, 1'b1);
        // unknown select locks again and reads back as all ones
        add_row(ACC_WRITE, CTL_PORT, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(ACC_READ,  DHI_PORT, 8'h00, 1'b1, UNKNOWN_READ, 1'b1, 1'b1);
        add_row(ACC_WRITE, 10'h3FF,  8'hFF, 1'b1, 8'h00, 1'b0, 1'b0);
        add_row(ACC_READ,  10'h000,  8'h00, 1'b1, 8'h00, 1'b0, 1'b0);
        add_row(ACC_READ,  CTL_PORT + 10'd3, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[j])
            send_access(directed_rows[j].wr, directed_rows[j].port, directed_rows[j].wd,
                        directed_rows[j].fixed, directed_rows[j].want);

        for (ph = 0; ph < 7; ph++) begin
            wait_idle();
            case (ph)
                0:       mode_val = 8'hFF;
                5:       mode_val = 8'h00;
                6:       mode_val = 8'($urandom_range(5, 254));
                default: mode_val = 8'(ph);
            endcase
            cfg_valid <= 1'b1;
            cfg_data  <= mode_val;
            do @(posedge aclk); while (!cfg_ready);
            cfg_valid   <= 1'b0;
            card_mode_m = mode_val;
            run_random_phase(170);
        end

        wait_idle();
        if (reply_mismatches == 0 && bus_replies_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> isa_card_control_registers_unit.f
rtl/core/iccr_pkg.sv
rtl/core/isa_card_control_registers_unit.sv
test/testbench.sv
